@@ rtl/clcd_pkg.sv @@
// ----------------------------------------------------------------------------
// clcd_pkg
// Types and constants shared by the character LCD cursor sequencer.
// ----------------------------------------------------------------------------
package clcd_pkg;

    // Operation selector carried on the input tuser
    typedef enum logic [1:0] {
        OP_PUT_CHAR = 2'd0,
        OP_GOTO     = 2'd1,
        OP_CLEAR    = 2'd2,
        OP_HOME     = 2'd3
    } t_op;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_LINE_ONE_START = 2'd0,
        CFG_LINE_ONE_END   = 2'd1,
        CFG_LINE_TWO_START = 2'd2,
        CFG_LINE_TWO_END   = 2'd3
    } t_cfg_idx;

    localparam int ADDR_W = 7;
    localparam int BYTE_W = 8;
    localparam int MAX_XACT = 3;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [1:0]        t_cnt;

    // Controller instruction bytes
    localparam logic [BYTE_W-1:0] CMD_CLEAR = 8'h01;
    localparam logic [BYTE_W-1:0] CMD_HOME  = 8'h02;
    localparam logic              CMD_DDRAM = 1'b1;   // top bit of set-address

    // Character codes with special meaning
    localparam logic [BYTE_W-1:0] CH_ETX   = 8'h03;
    localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

    // One LCD bus transaction
    typedef struct packed {
        logic              is_data;
        logic [BYTE_W-1:0] bus_byte;
    } t_xact;

    // Line geometry
    typedef struct packed {
        t_addr l1_start;
        t_addr l1_end;
        t_addr l2_start;
        t_addr l2_end;
    } t_geom;

    // Translation of one input item
    typedef struct packed {
        t_xact [MAX_XACT-1:0] xact;     // index 0 goes out first
        t_cnt                 cnt;      // 1 to 3
        t_addr                cursor;   // cursor after the item
    } t_xlate;

endpackage

@@ rtl/char_lcd_cursor_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// char_lcd_cursor_sequencer_unit
// Cursor sequencer for a two-line character LCD: operations in, bus
// transactions (register select plus byte) out.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake                  | payload
//  ---------+-----+----------------------------+------------------------------
//  s (ops)  | in  | i_s_tvalid / o_s_tready    | tuser: op; tdata: char, addr
//  m (bus)  | out | o_m_tvalid / i_m_tready    | tuser: is_data; tdata: byte;
//           |     |                            | tlast: final of the operation
//  cfg      | in  | i_cfg_valid / o_cfg_ready  | index, 7-bit value
//
// An operation is translated in the cycle it is accepted and its one to
// three transactions land in a result buffer, which drains one per cycle
// while i_m_tready is high. The next operation is taken when the buffer is
// empty or in the cycle the buffer hands out its final transaction. Reset
// restores the default line geometry and puts the cursor at address zero.
// Configuration is always ready.
// ----------------------------------------------------------------------------
module char_lcd_cursor_sequencer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // operation stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [15:0]                   i_s_tdata,  // [7:0] char_code, [14:8] target_address
    input  clcd_pkg::t_op                 i_s_tuser,  // [1:0] op
    // bus transaction stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [clcd_pkg::BYTE_W-1:0]   o_m_tdata,  // [7:0] bus_byte
    output logic                          o_m_tuser,  // [0] is_data
    output logic                          o_m_tlast,
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  clcd_pkg::t_cfg_idx            i_cfg_index,
    input  clcd_pkg::t_addr               i_cfg_data
);
    import clcd_pkg::*;

    t_geom                r_geom;
    t_addr                r_cursor;
    t_xact [MAX_XACT-1:0] r_buf;
    t_xact [MAX_XACT-1:0] n_buf;
    t_cnt                 r_cnt;
    t_cnt                 n_cnt;
    t_xlate               xl;
    logic                 s_acc;
    logic                 m_acc;

    assign o_cfg_ready = 1'b1;

    // Handshakes
    assign o_m_tvalid = (r_cnt != t_cnt'(0));
    assign m_acc      = o_m_tvalid && i_m_tready;
    assign o_s_tready = (r_cnt == t_cnt'(0)) || ((r_cnt == t_cnt'(1)) && i_m_tready);
    assign s_acc      = i_s_tvalid && o_s_tready;

    clcd_xlate u_xlate (
        .i_op             (i_s_tuser),
        .i_char_code      (i_s_tdata[7:0]),
        .i_target_address (i_s_tdata[14:8]),
        .i_cursor         (r_cursor),
        .i_geom           (r_geom),
        .o_res            (xl)
    );

    // Result buffer: load a whole operation, shift down on each pop
    always_comb begin
        n_buf = r_buf;
        n_cnt = r_cnt;
        if (s_acc) begin
            n_buf = xl.xact;
            n_cnt = xl.cnt;
        end else if (m_acc) begin
            n_buf[0] = r_buf[1];
            n_buf[1] = r_buf[2];
            n_cnt    = r_cnt - t_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Cursor follows each accepted operation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
        end else if (s_acc) begin
            r_cursor <= xl.cursor;
        end
    end

    // Line geometry registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.l1_start <= t_addr'(0);
            r_geom.l1_end   <= t_addr'(15);
            r_geom.l2_start <= t_addr'(64);
            r_geom.l2_end   <= t_addr'(79);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LINE_ONE_START: r_geom.l1_start <= i_cfg_data;
                CFG_LINE_ONE_END:   r_geom.l1_end   <= i_cfg_data;
                CFG_LINE_TWO_START: r_geom.l2_start <= i_cfg_data;
                CFG_LINE_TWO_END:   r_geom.l2_end   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Output port
    assign o_m_tdata = r_buf[0].bus_byte;
    assign o_m_tuser = r_buf[0].is_data;
    assign o_m_tlast = (r_cnt == t_cnt'(1));

endmodule

@@ rtl/clcd_xlate.sv @@
// ----------------------------------------------------------------------------
// clcd_xlate
// Turns one operation and the current cursor into up to three LCD bus
// transactions and the updated cursor address.
// ----------------------------------------------------------------------------
module clcd_xlate (
    input  clcd_pkg::t_op                 i_op,
    input  logic [clcd_pkg::BYTE_W-1:0]   i_char_code,
    input  clcd_pkg::t_addr               i_target_address,
    input  clcd_pkg::t_addr               i_cursor,
    input  clcd_pkg::t_geom               i_geom,
    output clcd_pkg::t_xlate              o_res
);
    import clcd_pkg::*;

    logic [ADDR_W:0] end1;
    logic [ADDR_W:0] end2;
    logic [ADDR_W:0] cur_ext;
    logic            is_newline;
    logic            is_erase;
    t_addr           back_addr;
    t_addr           base_addr;

    // End comparisons are done one bit wider so an end of 127 never matches
    assign end1    = {1'b0, i_geom.l1_end} + {{ADDR_W{1'b0}}, 1'b1};
    assign end2    = {1'b0, i_geom.l2_end} + {{ADDR_W{1'b0}}, 1'b1};
    assign cur_ext = {1'b0, i_cursor};

    assign is_newline = (i_char_code == CH_LF) || (i_char_code == CH_CR)
                     || (i_char_code == CH_ETX);
    assign is_erase   = (i_char_code == CH_BS) || (i_char_code == CH_DEL);

    // Erase target: hold at start of line one, jump back across the line break
    always_comb begin
        if (i_cursor == i_geom.l1_start) begin
            back_addr = i_cursor;
        end else if (i_cursor == i_geom.l2_start) begin
            back_addr = i_geom.l1_end;
        end else begin
            back_addr = i_cursor - t_addr'(1);
        end
    end

    // Cell that an ordinary character lands in after any wrap
    always_comb begin
        if (cur_ext == end1) begin
            base_addr = i_geom.l2_start;
        end else if (cur_ext == end2) begin
            base_addr = i_geom.l1_start;
        end else begin
            base_addr = i_cursor;
        end
    end

    // Transaction list
    always_comb begin
        o_res.xact[0] = '{is_data: 1'b0, bus_byte: {CMD_DDRAM, i_target_address}};
        o_res.xact[1] = '{is_data: 1'b1, bus_byte: CH_SPACE};
        o_res.xact[2] = '{is_data: 1'b0, bus_byte: {CMD_DDRAM, back_addr}};
        o_res.cnt     = t_cnt'(1);
        o_res.cursor  = i_target_address;
        case (i_op)
            OP_GOTO: begin
                o_res.cursor = i_target_address;
            end
            OP_CLEAR: begin
                o_res.xact[0] = '{is_data: 1'b0, bus_byte: CMD_CLEAR};
                o_res.cursor  = i_geom.l1_start;
            end
            OP_HOME: begin
                o_res.xact[0] = '{is_data: 1'b0, bus_byte: CMD_HOME};
                o_res.cursor  = i_geom.l1_start;
            end
            OP_PUT_CHAR: begin
                if (is_newline) begin
                    o_res.cursor  = (cur_ext <= end1) ? i_geom.l2_start
                                                      : i_geom.l1_start;
                    o_res.xact[0] = '{is_data: 1'b0,
                                      bus_byte: {CMD_DDRAM, o_res.cursor}};
                end else if (is_erase) begin
                    o_res.cursor  = back_addr;
                    o_res.xact[0] = '{is_data: 1'b0, bus_byte: {CMD_DDRAM, back_addr}};
                    o_res.cnt     = t_cnt'(3);
                end else begin
                    o_res.cursor = base_addr + t_addr'(1);
                    if (cur_ext == end1) begin
                        o_res.xact[0] = '{is_data: 1'b0,
                                          bus_byte: {CMD_DDRAM, i_geom.l2_start}};
                        o_res.xact[1] = '{is_data: 1'b1, bus_byte: i_char_code};
                        o_res.cnt     = t_cnt'(2);
                    end else if (cur_ext == end2) begin
                        o_res.xact[0] = '{is_data: 1'b0, bus_byte: CMD_CLEAR};
                        o_res.xact[1] = '{is_data: 1'b1, bus_byte: i_char_code};
                        o_res.cnt     = t_cnt'(2);
                    end else begin
                        o_res.xact[0] = '{is_data: 1'b1, bus_byte: i_char_code};
                    end
                end
            end
            default: begin
                o_res.cursor = i_cursor;
            end
        endcase
    end

endmodule
